// File: src/priority_task_scheduler_table_defines.svh
// assertion macros for the task scheduler checker
`ifndef PRIORITY_TASK_SCHEDULER_TABLE_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_TABLE_DEFINES_SVH
// property that holds on every edge outside reset
`define PTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// property checked also during reset
`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`endif

// File: src/pts_pkg.sv
// package: constants, types and helpers for the task scheduler
package pts_pkg;
   localparam int TaskSlots = 16;
   localparam int SlotW = $clog2(TaskSlots);
   localparam int CountW = $clog2(TaskSlots + 1);
   localparam int TicksW = 23;
   localparam logic [TicksW-1:0] TicksMax = {TicksW{1'b1}};
   localparam logic [16:0] TickRateReset = 17'd100;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0, CMD_DESTROY = 3'd1, CMD_YIELD = 3'd2, CMD_SLEEP = 3'd3,
      CMD_BLOCK = 3'd4, CMD_UNBLOCK = 3'd5, CMD_LOOKUP = 3'd6, CMD_NONE = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_READY = 2'd0, ST_RUNNING = 2'd1, ST_BLOCKED = 2'd2, ST_SLEEPING = 2'd3
   } run_state_type;

   typedef enum logic [1:0] {
      STS_DONE = 2'd0, STS_FULL = 2'd1, STS_MISSING = 2'd2, STS_IGNORED = 2'd3
   } status_type;

   // one slot's contents, moved along the chain
   typedef struct packed {
      logic                used;
      logic [15:0]         task_id;
      logic [7:0]          prio;
      run_state_type       run_state;
      logic [TicksW-1:0]   wait_ticks;
   } slot_type;

   // per-cycle control from the sequencer to every cell
   typedef struct packed {
      logic                shift;   // rotate the ring by one
      logic                write;   // overwrite the head slot with wdata
      slot_type            wdata;
   } cell_ctrl_type;
endpackage

// File: src/pts_cell.sv
// one slot cell of the rotating slot ring
module pts_cell
   import pts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  slot_type      reset_value,
   input  logic          is_head,
   input  cell_ctrl_type ctrl,
   input  slot_type      prev_slot,
   output slot_type      slot
);
   slot_type slot_ff, slot_in;

   // rotate, or take the write at the head position
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.shift) begin
         slot_in = prev_slot;
      end else if (ctrl.write && is_head) begin
         slot_in = ctrl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= reset_value;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;
endmodule

// File: src/priority_task_scheduler_table.sv
// top level: task slot ring and command sequencer
//
// channel  dir  ports
// req      in   req_valid req_ready req_command req_task_id req_priority_req req_sleep_ms
// rsp      out  rsp_valid rsp_ready rsp_status rsp_result_id rsp_running_id ...
// csr      in   csr_write_en csr_write_data
//
// slots sit in a ring of TaskSlots cells; the head cell is read and written.
// every command makes one full scan rotation; a command that writes then rotates
// to its slot; yield, sleep and destroy of the running task add a scheduling pass
// and a rotation to mark the winner, and then the result beat shows.
// reset is synchronous; a waiting result holds req_ready low until rsp_ready.
module priority_task_scheduler_table
   import pts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_task_id,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_sleep_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_result_id,
   output logic [15:0] rsp_running_id,
   output logic        rsp_switched,
   output logic [1:0]  rsp_found_state,
   output logic [7:0]  rsp_found_priority,
   output logic [22:0] rsp_found_sleep_ticks,
   input  logic        csr_write_en,
   input  logic [16:0] csr_write_data
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,   // find target / free slot, one rotation
      S_APPLY = 6'b000100,   // rotate until the target is at head, write it
      S_SCHED = 6'b001000,   // pick best ready slot, one rotation
      S_MARK  = 6'b010000,   // rotate to the chosen slot, mark running
      S_RESP  = 6'b100000
   } state_type;

   localparam logic [30:0] Recip125 = 31'd1099511627;   // floor(2^37 / 125)

   state_type state_ff, state_in;
   logic [16:0] rate_ff;
   cmd_type cmd_ff;
   logic [15:0] id_ff;
   logic [7:0] prio_ff;
   logic [15:0] ms_ff;
   logic [SlotW-1:0] pos_ff, pos_in;     // slot index at head
   logic [SlotW-1:0] cnt_ff, cnt_in;     // step counter in a pass
   logic [SlotW-1:0] tgt_ff, tgt_in;     // target slot
   logic tgt_ok_ff, tgt_ok_in;
   logic [SlotW-1:0] run_ff, run_in;     // running slot
   logic [SlotW-1:0] prev_run_ff, prev_run_in;
   logic [15:0] fresh_ff, fresh_in;
   logic [CountW-1:0] used_ff, used_in;
   logic [SlotW-1:0] best_ff, best_in;
   logic best_ok_ff, best_ok_in;
   logic [7:0] best_prio_ff, best_prio_in;
   logic [15:0] best_id_ff, best_id_in;
   logic [15:0] run_id_ff, run_id_in;
   logic [32:0] prod_ff;
   logic [23:0] q_est_ff;
   logic do_sched_ff, do_sched_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] st_ff, st_in;
   logic [15:0] rid_ff, rid_in;
   logic sw_ff, sw_in;
   logic [1:0] fst_ff, fst_in;
   logic [7:0] fpr_ff, fpr_in;
   logic [TicksW-1:0] ftk_ff, ftk_in;
   cell_ctrl_type ctrl;
   slot_type slots [TaskSlots];
   slot_type head;
   logic [TicksW-1:0] ticks;
   logic [29:0] p8;
   logic [60:0] est_prod;
   logic [30:0] q_rem;
   logic [23:0] q_fix;

   assign head = slots[0];

   // ring of cells, cell 0 is head; shifting brings cell 1 to head
   for (genvar g = 0; g < TaskSlots; g++) begin : g_cell
      slot_type rv;
      always_comb begin
         rv = '0;
         rv.used = (g == 0);
         rv.run_state = ST_READY;
      end
      pts_cell u_cell (
         .clock(clock), .reset(reset), .reset_value(rv), .is_head(g == 0),
         .ctrl(ctrl), .prev_slot(slots[(g + 1) % TaskSlots]), .slot(slots[g])
      );
   end

   // sleep ticks: ms*rate/1000 as (ms*rate >> 3)/125; the reciprocal estimate
   // is registered and is at most one low, fixed by one compare, then saturated
   always_comb begin
      p8 = prod_ff[32:3];
      est_prod = 61'(p8) * 61'(Recip125);
      q_rem = 31'(p8) - 31'(q_est_ff) * 31'd125;
      q_fix = (q_rem >= 31'd125) ? q_est_ff + 24'd1 : q_est_ff;
      ticks = (q_fix > 24'(TicksMax)) ? TicksMax : q_fix[TicksW-1:0];
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   // sequencer
   always_comb begin
      slot_type w;
      logic better;
      logic last;
      state_in = state_ff; pos_in = pos_ff; cnt_in = cnt_ff; tgt_in = tgt_ff;
      tgt_ok_in = tgt_ok_ff; run_in = run_ff; prev_run_in = prev_run_ff;
      fresh_in = fresh_ff; used_in = used_ff; best_in = best_ff;
      best_ok_in = best_ok_ff; best_prio_in = best_prio_ff; best_id_in = best_id_ff;
      run_id_in = run_id_ff; do_sched_in = do_sched_ff; rsp_valid_in = rsp_valid_ff;
      st_in = st_ff; rid_in = rid_ff; sw_in = sw_ff; fst_in = fst_ff;
      fpr_in = fpr_ff; ftk_in = ftk_ff;
      ctrl = '0;
      w = head;
      better = 1'b0;
      last = (cnt_ff == SlotW'(TaskSlots - 1));
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               st_in = STS_DONE; rid_in = '0; sw_in = 1'b0;
               fst_in = '0; fpr_in = '0; ftk_in = '0;
               cnt_in = '0; tgt_ok_in = 1'b0; do_sched_in = 1'b0;
               prev_run_in = run_ff;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // the ring may start anywhere; keep the lowest matching slot index
            if (!tgt_ok_ff || pos_ff < tgt_ff) begin
               if (cmd_ff == CMD_CREATE) begin
                  if (!head.used && pos_ff != '0) begin
                     tgt_ok_in = 1'b1; tgt_in = pos_ff;
                  end
               end else if (head.used && head.task_id == id_ff) begin
                  tgt_ok_in = 1'b1; tgt_in = pos_ff;
               end
            end
            ctrl.shift = 1'b1;
            pos_in = pos_ff + SlotW'(1);
            cnt_in = cnt_ff + SlotW'(1);
            if (cmd_ff == CMD_YIELD || cmd_ff == CMD_SLEEP) begin
               tgt_ok_in = 1'b1; tgt_in = run_ff;
            end
            if (last) begin
               state_in = S_APPLY;
               case (cmd_ff)
                  CMD_CREATE:  if (used_ff >= CountW'(TaskSlots) || !tgt_ok_in) begin
                     st_in = STS_FULL; state_in = S_RESP;
                  end
                  CMD_DESTROY, CMD_BLOCK, CMD_UNBLOCK, CMD_LOOKUP: begin
                     if (!tgt_ok_in) begin
                        st_in = STS_MISSING; state_in = S_RESP;
                     end else if (cmd_ff == CMD_DESTROY && tgt_in == '0) begin
                        st_in = STS_IGNORED; state_in = S_RESP;
                     end
                  end
                  CMD_SLEEP: if (run_ff == '0) begin
                     st_in = STS_IGNORED; state_in = S_RESP;
                  end
                  CMD_YIELD: ;
                  default: begin
                     st_in = STS_IGNORED; state_in = S_RESP;
                  end
               endcase
            end
         end
         S_APPLY: begin
            if (pos_ff != tgt_ff) begin
               ctrl.shift = 1'b1;
               pos_in = pos_ff + SlotW'(1);
            end else begin
               ctrl.write = 1'b1;
               state_in = S_RESP;
               case (cmd_ff)
                  CMD_CREATE: begin
                     w.used = 1'b1; w.task_id = fresh_ff; w.prio = prio_ff;
                     w.run_state = ST_READY; w.wait_ticks = '0;
                     rid_in = fresh_ff; fresh_in = fresh_ff + 16'd1;
                     used_in = used_ff + CountW'(1);
                  end
                  CMD_DESTROY: begin
                     w = '0; w.run_state = ST_READY;
                     used_in = used_ff - CountW'(1);
                     if (tgt_ff == run_ff) do_sched_in = 1'b1;
                  end
                  CMD_YIELD: begin
                     w.run_state = ST_READY; do_sched_in = 1'b1;
                  end
                  CMD_SLEEP: begin
                     w.run_state = ST_SLEEPING; w.wait_ticks = ticks;
                     do_sched_in = 1'b1;
                  end
                  CMD_BLOCK: w.run_state = ST_BLOCKED;
                  CMD_UNBLOCK: w.run_state = ST_READY;
                  CMD_LOOKUP: begin
                     rid_in = head.task_id; fst_in = head.run_state;
                     fpr_in = head.prio; ftk_in = head.wait_ticks;
                  end
                  default: ;
               endcase
               ctrl.wdata = w;
               if (do_sched_in) begin
                  state_in = S_SCHED; cnt_in = '0; best_ok_in = 1'b0; best_in = '0;
               end
            end
         end
         S_SCHED: begin
            // full tie on priority and id goes to the lower slot index
            better = !best_ok_ff || head.prio > best_prio_ff ||
                     (head.prio == best_prio_ff && head.task_id < best_id_ff) ||
                     (head.prio == best_prio_ff && head.task_id == best_id_ff &&
                      pos_ff < best_ff);
            if (head.used && head.run_state == ST_READY && better) begin
               best_ok_in = 1'b1; best_in = pos_ff;
               best_prio_in = head.prio; best_id_in = head.task_id;
            end
            ctrl.shift = 1'b1;
            pos_in = pos_ff + SlotW'(1);
            cnt_in = cnt_ff + SlotW'(1);
            if (last) state_in = S_MARK;
         end
         S_MARK: begin
            if (pos_ff != best_ff) begin
               ctrl.shift = 1'b1;
               pos_in = pos_ff + SlotW'(1);
            end else begin
               w.run_state = ST_RUNNING;
               ctrl.write = 1'b1; ctrl.wdata = w;
               run_in = best_ff;
               run_id_in = head.task_id;
               sw_in = (best_ff != prev_run_ff);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rate_ff <= TickRateReset; pos_ff <= '0; run_ff <= '0;
         fresh_ff <= 16'd1; used_ff <= CountW'(1); rsp_valid_ff <= 1'b0;
         run_id_ff <= '0; cnt_ff <= '0; tgt_ok_ff <= 1'b0; do_sched_ff <= 1'b0;
         best_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pos_ff <= pos_in; run_ff <= run_in;
         fresh_ff <= fresh_in; used_ff <= used_in; rsp_valid_ff <= rsp_valid_in;
         run_id_ff <= run_id_in; cnt_ff <= cnt_in; tgt_ok_ff <= tgt_ok_in;
         do_sched_ff <= do_sched_in; best_ok_ff <= best_ok_in;
         if (csr_write_en) rate_ff <= csr_write_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_type'(req_command); id_ff <= req_task_id;
         prio_ff <= req_priority_req; ms_ff <= req_sleep_ms;
      end
      prod_ff <= 33'(ms_ff) * 33'(rate_ff);
      q_est_ff <= est_prod[60:37];
      tgt_ff <= tgt_in; prev_run_ff <= prev_run_in;
      best_ff <= best_in; best_prio_ff <= best_prio_in; best_id_ff <= best_id_in;
      st_ff <= st_in; rid_ff <= rid_in; sw_ff <= sw_in; fst_ff <= fst_in;
      fpr_ff <= fpr_in; ftk_ff <= ftk_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = st_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_running_id = run_id_ff;
   assign rsp_switched = sw_ff;
   assign rsp_found_state = fst_ff;
   assign rsp_found_priority = fpr_ff;
   assign rsp_found_sleep_ticks = ftk_ff;
endmodule

// File: src/pts_checker.sv
// port-level checker for the task scheduler, bound to the top level
`include "priority_task_scheduler_table_defines.svh"
module pts_checker
   import pts_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_switched
);
   // a held result beat stays valid and keeps its status
   `PTS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "rsp dropped")
   // no new beat is taken while a result waits
   `PTS_ASSERT(a_no_accept, rsp_valid |-> !req_ready, "req taken with result pending")
   // an accepted beat is not answered in the next cycle
   `PTS_ASSERT(a_latency, req_valid && req_ready |=> !rsp_valid, "result too early")
   // refused or missing commands never switch tasks
   `PTS_ASSERT(a_no_switch, rsp_valid && rsp_status != STS_DONE |-> !rsp_switched, "bad switch")
   // reset leaves no result pending
   `PTS_ASSERT_ALWAYS(a_reset, reset |=> !rsp_valid, "rsp after reset")
endmodule

bind priority_task_scheduler_table pts_checker u_pts_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_switched(rsp_switched)
);

// File: test/tb_priority_task_scheduler_table.sv
// testbench for the priority task scheduler table: directed table plus random commands
`timescale 1ns / 1ps
module tb_priority_task_scheduler_table;
   import pts_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_command = CMD_NONE;
   logic [15:0] req_task_id = '0;
   logic [7:0]  req_priority_req = '0;
   logic [15:0] req_sleep_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_result_id;
   logic [15:0] rsp_running_id;
   logic        rsp_switched;
   logic [1:0]  rsp_found_state;
   logic [7:0]  rsp_found_priority;
   logic [22:0] rsp_found_sleep_ticks;
   logic        csr_write_en = 1'b0;
   logic [16:0] csr_write_data = '0;

   priority_task_scheduler_table dut (.*);

   always #1 clock = ~clock;

   // one result beat
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_id;
      logic [15:0] running_id;
      logic        switched;
      logic [1:0]  found_state;
      logic [7:0]  found_priority;
      logic [22:0] found_sleep_ticks;
   } outcome_type;

   // directed row: command fields, and an outcome typed in where obvious
   typedef struct {
      cmd_type     cmd;
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] ms;
      logic        typed;
      outcome_type want;
   } row_type;

   // scheduler mirror
   logic [16:0]         tick_rate;
   logic                m_used [TaskSlots];
   logic [15:0]         m_id [TaskSlots];
   logic [7:0]          m_prio [TaskSlots];
   run_state_type       m_state [TaskSlots];
   logic [TicksW-1:0]   m_ticks [TaskSlots];
   int                  m_running;
   logic [15:0]         m_fresh;
   int                  m_count;

   outcome_type pending_outcomes[$];
   int  errors = 0;
   int  sent = 0;
   int  received = 0;
   int  hold_cycles = 0;
   bit  stim_done = 0;

   task automatic mirror_reset();
      for (int i = 0; i < TaskSlots; i++) begin
         m_used[i] = (i == 0);
         m_id[i] = '0;
         m_prio[i] = '0;
         m_state[i] = ST_READY;
         m_ticks[i] = '0;
      end
      m_running = 0;
      m_fresh = 16'd1;
      m_count = 1;
      tick_rate = TickRateReset;
   endtask

   function automatic int slot_of(logic [15:0] id);
      for (int i = 0; i < TaskSlots; i++)
         if (m_used[i] && m_id[i] == id) return i;
      return -1;
   endfunction

   function automatic logic pick_task(int prev);
      int best;
      best = -1;
      for (int i = 0; i < TaskSlots; i++) begin
         if (!m_used[i] || m_state[i] != ST_READY) continue;
         if (best < 0 || m_prio[i] > m_prio[best] ||
             (m_prio[i] == m_prio[best] && m_id[i] < m_id[best]))
            best = i;
      end
      if (best < 0) best = 0;
      m_running = best;
      m_state[best] = ST_RUNNING;
      return best != prev;
   endfunction

   // advance the mirror by one command and return its outcome
   function automatic outcome_type schedule_step(logic [2:0] cmd, logic [15:0] id,
                                                 logic [7:0] prio, logic [15:0] ms);
      outcome_type o;
      int s;
      logic [63:0] t;
      o = '0;
      case (cmd)
         CMD_CREATE: begin
            s = -1;
            if (m_count < TaskSlots)
               for (int i = 1; i < TaskSlots; i++)
                  if (!m_used[i]) begin s = i; break; end
            if (s < 0) o.status = STS_FULL;
            else begin
               m_used[s] = 1'b1;
               m_id[s] = m_fresh;
               m_prio[s] = prio;
               m_state[s] = ST_READY;
               m_ticks[s] = '0;
               o.result_id = m_fresh;
               m_fresh = m_fresh + 16'd1;
               m_count++;
            end
         end
         CMD_DESTROY: begin
            s = slot_of(id);
            if (s < 0) o.status = STS_MISSING;
            else if (s == 0) o.status = STS_IGNORED;
            else begin
               m_used[s] = 1'b0;
               m_id[s] = '0;
               m_prio[s] = '0;
               m_state[s] = ST_READY;
               m_ticks[s] = '0;
               m_count--;
               if (s == m_running) o.switched = pick_task(s);
            end
         end
         CMD_YIELD: begin
            s = m_running;
            m_state[s] = ST_READY;
            o.switched = pick_task(s);
         end
         CMD_SLEEP: begin
            s = m_running;
            if (s == 0) o.status = STS_IGNORED;
            else begin
               t = (64'(ms) * 64'(tick_rate)) / 64'd1000;
               m_ticks[s] = (t > 64'(TicksMax)) ? TicksMax : t[TicksW-1:0];
               m_state[s] = ST_SLEEPING;
               o.switched = pick_task(s);
            end
         end
         CMD_BLOCK, CMD_UNBLOCK: begin
            s = slot_of(id);
            if (s < 0) o.status = STS_MISSING;
            else m_state[s] = (cmd == CMD_BLOCK) ? ST_BLOCKED : ST_READY;
         end
         CMD_LOOKUP: begin
            s = slot_of(id);
            if (s < 0) o.status = STS_MISSING;
            else begin
               o.result_id = m_id[s];
               o.found_state = m_state[s];
               o.found_priority = m_prio[s];
               o.found_sleep_ticks = m_ticks[s];
            end
         end
         default: o.status = STS_IGNORED;
      endcase
      o.running_id = m_id[m_running];
      return o;
   endfunction

   // send one command beat, after a random gap; returns right after the accept
   task automatic send_command(logic [2:0] cmd, logic [15:0] id, logic [7:0] prio,
                               logic [15:0] ms, logic typed, outcome_type want);
      outcome_type o;
      int gap;
      @(negedge clock);
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      o = schedule_step(cmd, id, prio, ms);
      if (typed && o !== want) begin
         $error("directed row %0d: table says %h, predictor says %h", sent, want, o);
         errors++;
      end
      pending_outcomes.push_back(o);
      req_command <= cmd;
      req_task_id <= id;
      req_priority_req <= prio;
      req_sleep_ms <= ms;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // drop valid, drain, pause for the block's tail, then write the rate register
   task automatic set_tick_rate(logic [16:0] rate);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (2 * TaskSlots + 8) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= rate;
      tick_rate = rate;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic outcome_type want_of(logic [1:0] st, logic [15:0] rid,
                                           logic [15:0] run, logic sw);
      outcome_type o;
      o = '0;
      o.status = st;
      o.result_id = rid;
      o.running_id = run;
      o.switched = sw;
      return o;
   endfunction

   // random command, mostly well-formed against live ids
   task automatic send_random();
      logic [2:0]  cmd;
      logic [15:0] id;
      int          s;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 22) cmd = CMD_CREATE;
      else if (pick < 34) cmd = CMD_DESTROY;
      else if (pick < 48) cmd = CMD_YIELD;
      else if (pick < 58) cmd = CMD_SLEEP;
      else if (pick < 68) cmd = CMD_BLOCK;
      else if (pick < 80) cmd = CMD_UNBLOCK;
      else if (pick < 97) cmd = CMD_LOOKUP;
      else cmd = CMD_NONE;
      s = $urandom_range(0, TaskSlots - 1);
      if ($urandom_range(0, 9) < 8 && m_used[s]) id = m_id[s];
      else id = 16'($urandom);
      send_command(cmd, id, 8'($urandom), 16'($urandom), 1'b0, '0);
   endtask

   // result side: random stalls, one long hold-off, compare each beat
   initial begin
      outcome_type got, exp;
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (received == 40 && hold_cycles == 0) begin
            rsp_ready <= 1'b0;
            while (hold_cycles < 400) begin
               @(negedge clock);
               hold_cycles++;
            end
         end else begin
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = {rsp_status, rsp_result_id, rsp_running_id, rsp_switched,
                rsp_found_state, rsp_found_priority, rsp_found_sleep_ticks};
         received++;
         if (pending_outcomes.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            exp = pending_outcomes.pop_front();
            if (got.status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
            end
            if (got.result_id !== exp.result_id) begin
               $error("result_id: expected %0d, got %0d", exp.result_id, got.result_id);
               errors++;
            end
            if (got.running_id !== exp.running_id) begin
               $error("running_id: expected %0d, got %0d", exp.running_id, got.running_id);
               errors++;
            end
            if (got.switched !== exp.switched) begin
               $error("switched: expected %0d, got %0d", exp.switched, got.switched);
               errors++;
            end
            if (got.found_state !== exp.found_state) begin
               $error("found_state: expected %0d, got %0d", exp.found_state,
                      got.found_state);
               errors++;
            end
            if (got.found_priority !== exp.found_priority) begin
               $error("found_priority: expected %0d, got %0d", exp.found_priority,
                      got.found_priority);
               errors++;
            end
            if (got.found_sleep_ticks !== exp.found_sleep_ticks) begin
               $error("found_sleep_ticks: expected %0d, got %0d", exp.found_sleep_ticks,
                      got.found_sleep_ticks);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // stimulus: reset, directed table, random phases across rate settings
   initial begin
      row_type rows[$];
      logic [16:0] rates[5];
      mirror_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rows = '{
         '{CMD_LOOKUP, 16'd0, 8'd0, 16'd0, 1'b1, want_of(STS_DONE, 16'd0, 16'd0, 1'b0)},
         '{CMD_SLEEP, 16'd0, 8'd0, 16'hFFFF, 1'b1,
           want_of(STS_IGNORED, 16'd0, 16'd0, 1'b0)},
         '{CMD_DESTROY, 16'd0, 8'd0, 16'd0, 1'b1,
           want_of(STS_IGNORED, 16'd0, 16'd0, 1'b0)},
         '{CMD_DESTROY, 16'hFFFF, 8'd0, 16'd0, 1'b1,
           want_of(STS_MISSING, 16'd0, 16'd0, 1'b0)},
         '{CMD_BLOCK, 16'h7777, 8'd0, 16'd0, 1'b1,
           want_of(STS_MISSING, 16'd0, 16'd0, 1'b0)},
         '{CMD_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1,
           want_of(STS_IGNORED, 16'd0, 16'd0, 1'b0)},
         '{CMD_CREATE, 16'd0, 8'hFF, 16'd0, 1'b1, want_of(STS_DONE, 16'd1, 16'd0, 1'b0)},
         '{CMD_CREATE, 16'd0, 8'd0, 16'd0, 1'b1, want_of(STS_DONE, 16'd2, 16'd0, 1'b0)},
         '{CMD_CREATE, 16'd0, 8'hFF, 16'd0, 1'b1, want_of(STS_DONE, 16'd3, 16'd0, 1'b0)},
         '{CMD_YIELD, 16'd0, 8'd0, 16'd0, 1'b1, want_of(STS_DONE, 16'd0, 16'd1, 1'b1)},
         '{CMD_SLEEP, 16'd0, 8'd0, 16'hFFFF, 1'b0, '0},
         '{CMD_LOOKUP, 16'd1, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_BLOCK, 16'd3, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_YIELD, 16'd0, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_UNBLOCK, 16'd3, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_BLOCK, 16'd0, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_YIELD, 16'd0, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_DESTROY, 16'd3, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_UNBLOCK, 16'd0, 8'd0, 16'd0, 1'b0, '0},
         '{CMD_LOOKUP, 16'd2, 8'd0, 16'd0, 1'b0, '0}
      };
      foreach (rows[r])
         send_command(rows[r].cmd, rows[r].id, rows[r].prio, rows[r].ms,
                      rows[r].typed, rows[r].want);
      // fill the table past full
      repeat (TaskSlots) send_command(CMD_CREATE, 16'd0, 8'($urandom), 16'd0, 1'b0, '0);
      rates = '{17'd1, 17'd100000, 17'h1FFFF, 17'd1000, 17'd0};
      for (int ph = 0; ph < 5; ph++) begin
         set_tick_rate(ph == 4 ? 17'($urandom_range(1, 100000)) : rates[ph]);
         repeat (145) send_random();
      end
      @(negedge clock);
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // end of run: drain, let the block settle, report
   initial begin
      wait (stim_done && pending_outcomes.size() == 0);
      repeat (2 * TaskSlots + 8) @(posedge clock);
      $display("covered %0d commands, %0d results checked, five tick rate settings",
               sent, received);
      $display("receiver held off %0d cycles while the sender kept offering", hold_cycles);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
